@@ sv/lphjt_pkg.sv @@
// lphjt_pkg: shared types and constants for the linear probe hash join table
// item kinds, back end states, field widths and register map
// no dependencies
package lphjt_pkg;

	localparam int MAX_LOG2_SLOTS_DEF = 10;
	localparam int KEY_BITS_DEF       = 32;

	localparam int KEY_IN_W   = 32;
	localparam int KIND_W     = 2;
	localparam int SLOT_OUT_W = 10;
	localparam int COUNT_W    = 32;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;

	localparam int CFG_DATA_W = 32;
	localparam int PADDR_W    = 3;
	localparam int LOG2_W     = 4;

	localparam logic              REG_IDX_TABLE_LOG2 = 1'b0;
	localparam logic [LOG2_W-1:0] TABLE_LOG2_RESET   = 4'd10;

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_PROBE  = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_SWEEP = 2'd0,
		ST_IDLE  = 2'd1,
		ST_CHECK = 2'd2,
		ST_DONE  = 2'd3
	} state_t;

endpackage

@@ sv/lphjt_front.sv @@
// lphjt_front: accepts stream words, works out key, home slot and slot mask,
// and holds them in a two-entry queue for the back end
// depends on lphjt_pkg
module lphjt_front #(
	parameter int MAX_LOG2_SLOTS = lphjt_pkg::MAX_LOG2_SLOTS_DEF,
	parameter int KEY_BITS       = lphjt_pkg::KEY_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [lphjt_pkg::IN_DATA_W-1:0] s_tdata,   // [31:0] key
	input  logic [lphjt_pkg::KIND_W-1:0]    s_tuser,   // [1:0] kind
	input  logic [lphjt_pkg::LOG2_W-1:0]    table_log2,
	input  logic                            init_busy,
	output logic                            q_valid,
	input  logic                            q_ready,
	output lphjt_pkg::kind_t                q_kind,
	output logic [KEY_BITS-1:0]             q_key,
	output logic [MAX_LOG2_SLOTS-1:0]       q_home,
	output logic [MAX_LOG2_SLOTS-1:0]       q_mask
);
	import lphjt_pkg::*;

	localparam int SW = MAX_LOG2_SLOTS;

	kind_t                 kind_q [2];
	logic [KEY_BITS-1:0]   key_q  [2];
	logic [SW-1:0]         home_q [2];
	logic [SW-1:0]         mask_q [2];
	logic                  wr_ptr_q, rd_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push, pop;
	logic [KEY_BITS+KEY_IN_W-1:0] key_ext;
	logic [KEY_BITS-1:0]   key_d;
	logic [SW+KEY_BITS-1:0] home_ext;
	logic [SW-1:0]         mask_d;

	always_comb begin
		key_ext  = {{KEY_BITS{1'b0}}, s_tdata[KEY_IN_W-1:0]};
		key_d    = key_ext[KEY_BITS-1:0];
		home_ext = {{SW{1'b0}}, key_d};
		// size below one is taken as one, above the maximum as the maximum
		mask_d    = '0;
		mask_d[0] = 1'b1;
		for (int i = 1; i < SW; i++) begin
			mask_d[i] = (32'(table_log2) > i);
		end
	end

	assign s_tready = (cnt_q != 2'd2) && !init_busy;
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign pop      = q_valid && q_ready;

	assign q_kind = kind_q[rd_ptr_q];
	assign q_key  = key_q[rd_ptr_q];
	assign q_home = home_q[rd_ptr_q];
	assign q_mask = mask_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= kind_t'(s_tuser);
			key_q[wr_ptr_q]  <= key_d;
			home_q[wr_ptr_q] <= home_ext[SW-1:0] & mask_d;
			mask_q[wr_ptr_q] <= mask_d;
		end
	end

endmodule

@@ sv/lphjt_back.sv @@
// lphjt_back: walks the slot memory for inserts and probes, sweeps it clear,
// keeps the hit count and holds the result word for the output stream
// depends on lphjt_pkg
module lphjt_back #(
	parameter int MAX_LOG2_SLOTS = lphjt_pkg::MAX_LOG2_SLOTS_DEF,
	parameter int KEY_BITS       = lphjt_pkg::KEY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  lphjt_pkg::kind_t                 q_kind,
	input  logic [KEY_BITS-1:0]              q_key,
	input  logic [MAX_LOG2_SLOTS-1:0]        q_home,
	input  logic [MAX_LOG2_SLOTS-1:0]        q_mask,
	output logic                             init_busy,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lphjt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import lphjt_pkg::*;

	localparam int SW    = MAX_LOG2_SLOTS;
	localparam int DEPTH = 1 << SW;
	localparam int MW    = KEY_BITS + 1;

	state_t state_q, state_d;

	// slot memory: occupied bit on top of the stored key
	logic [MW-1:0]       mem [DEPTH];
	logic [MW-1:0]       rdata_s1;
	logic                mem_we;
	logic [SW-1:0]       waddr, raddr;
	logic [MW-1:0]       wdata;

	kind_t               kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SW-1:0]       idx_q, home_q, mask_q, clr_idx_q, res_slot_q;
	logic                res_matched_q, res_full_q;
	logic [COUNT_W-1:0]  hit_total_q;
	logic                init_q;

	logic                   out_valid_q, out_matched_q, out_full_q;
	logic [SLOT_OUT_W-1:0]  out_slot_q;
	logic [COUNT_W-1:0]     out_count_q;
	logic [SW+SLOT_OUT_W-1:0] slot_ext;

	logic [SW-1:0] nxt_idx;
	logic occ, key_eq, wrapped, sweep_last, out_free, is_probe;
	logic take, hit, stop_here, stop_full, load_out;

	always_comb begin
		occ        = rdata_s1[KEY_BITS];
		key_eq     = (rdata_s1[KEY_BITS-1:0] == key_q);
		nxt_idx    = (idx_q + 1'b1) & mask_q;
		wrapped    = (nxt_idx == home_q);
		sweep_last = (clr_idx_q == {SW{1'b1}});
		out_free   = !out_valid_q || m_tready;
		is_probe   = (kind_q == KIND_PROBE);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_SWEEP: begin
				if (sweep_last) state_d = init_q ? ST_IDLE : ST_DONE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					unique case (q_kind)
						KIND_INSERT, KIND_PROBE: state_d = ST_CHECK;
						KIND_CLEAR:              state_d = ST_SWEEP;
						default:                 state_d = ST_DONE;
					endcase
				end
			end
			ST_CHECK: begin
				if (!occ || (is_probe && key_eq) || wrapped) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		q_ready   = (state_q == ST_IDLE);
		take      = q_ready && q_valid;
		raddr     = (state_q == ST_IDLE) ? q_home : nxt_idx;
		mem_we    = 1'b0;
		waddr     = idx_q;
		wdata     = {1'b1, key_q};
		hit       = 1'b0;
		stop_here = 1'b0;
		stop_full = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_SWEEP: begin
				mem_we = 1'b1;
				waddr  = clr_idx_q;
				wdata  = '0;
			end
			ST_CHECK: begin
				stop_here = !occ || (is_probe && key_eq);
				stop_full = !stop_here && wrapped;
				hit       = is_probe && occ && key_eq;
				mem_we    = (kind_q == KIND_INSERT) && !occ;
			end
			ST_DONE: load_out = out_free;
			default: ;
		endcase
		init_busy = init_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			init_q      <= 1'b1;
			clr_idx_q   <= '0;
			hit_total_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SWEEP) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (sweep_last) init_q <= 1'b0;
			end
			if (take && q_kind == KIND_CLEAR)        hit_total_q <= '0;
			else if (hit && hit_total_q != '1)       hit_total_q <= hit_total_q + 1'b1;
			if (load_out)      out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			kind_q        <= q_kind;
			key_q         <= q_key;
			home_q        <= q_home;
			mask_q        <= q_mask;
			idx_q         <= q_home;
			res_slot_q    <= '0;
			res_matched_q <= 1'b0;
			res_full_q    <= 1'b0;
		end else if (state_q == ST_CHECK) begin
			if (stop_here) begin
				res_slot_q    <= idx_q;
				res_matched_q <= hit;
			end else if (stop_full) begin
				res_slot_q <= home_q;
				res_full_q <= (kind_q == KIND_INSERT);
			end else begin
				idx_q <= nxt_idx;
			end
		end
		if (load_out) begin
			out_matched_q <= res_matched_q;
			out_slot_q    <= slot_ext[SLOT_OUT_W-1:0];
			out_full_q    <= res_full_q;
			out_count_q   <= hit_total_q;
		end
	end

	assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_q};

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		rdata_s1 <= mem[raddr];
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - COUNT_W - SLOT_OUT_W - 2){1'b0}},
		out_count_q, out_full_q, out_slot_q, out_matched_q};

`ifndef NO_ASSERTIONS
	a_no_walk_during_init: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> !init_q)
		else $error("slot walk started before the reset sweep ended");

	a_idx_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK) |-> ((idx_q & ~mask_q) == '0))
		else $error("walk index outside the slots in use");

	a_count_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=>
		(hit_total_q == $past(hit_total_q) || hit_total_q == $past(hit_total_q) + 1'b1))
		else $error("hit count moved by more than one outside a clear");

	a_full_not_matched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_matched_q && out_full_q))
		else $error("result flags both a match and a full table");
`endif

endmodule

@@ sv/linear_probe_hash_join_table.sv @@
// Hash join table with open addressing and linear probing.
// Input stream: s_tuser carries the kind (insert, probe, clear), s_tdata the
// 32-bit key. Each word yields one output word on m_tdata: matched, slot,
// table_full and the running saturating hit count.
// The APB port holds table_log2 at address 0 (log2 of slots in use, clamped to
// 1..MAX_LOG2_SLOTS); write it only while the block is idle.
// Walk: an insert or probe walks its slots one slot per cycle, set by the slot
// memory read; the engine takes the word while idle, checks slots in its check
// state and loads the result behind m_tvalid in its done state when free.
// A clear sweeps all 2**MAX_LOG2_SLOTS slots, one a cycle, then reports.
// After reset the same sweep runs with s_tready low; configuration writes
// are taken throughout.
// A two-word queue sits in front of the walk engine, so words keep being taken
// while a result waits in the output register; when m_tready stays low the
// engine stops at its result and the queue fills before s_tready drops.
// depends on lphjt_pkg, lphjt_front, lphjt_back
module linear_probe_hash_join_table #(
	parameter int MAX_LOG2_SLOTS = lphjt_pkg::MAX_LOG2_SLOTS_DEF,
	parameter int KEY_BITS       = lphjt_pkg::KEY_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lphjt_pkg::IN_DATA_W-1:0]  s_tdata,  // [31:0] key
	input  logic [lphjt_pkg::KIND_W-1:0]     s_tuser,  // [1:0] kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] matched, [10:1] slot, [11] table_full, [43:12] match_count, rest zero
	output logic [lphjt_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [lphjt_pkg::PADDR_W-1:0]    paddr,
	input  logic [lphjt_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [lphjt_pkg::CFG_DATA_W-1:0] prdata,
	output logic                             pready
);
	import lphjt_pkg::*;

	logic [LOG2_W-1:0]         table_log2_q;
	logic                      reg_hit, cfg_we, init_busy;
	logic                      q_valid, q_ready;
	kind_t                     q_kind;
	logic [KEY_BITS-1:0]       q_key;
	logic [MAX_LOG2_SLOTS-1:0] q_home, q_mask;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1] == REG_IDX_TABLE_LOG2);
	assign cfg_we  = psel && penable && pwrite && pready && reg_hit;
	assign prdata  = reg_hit ? {{(CFG_DATA_W - LOG2_W){1'b0}}, table_log2_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_log2_q <= TABLE_LOG2_RESET;
		end else if (cfg_we) begin
			table_log2_q <= pwdata[LOG2_W-1:0];
		end
	end

	lphjt_front #(
		.MAX_LOG2_SLOTS(MAX_LOG2_SLOTS),
		.KEY_BITS      (KEY_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.table_log2(table_log2_q),
		.init_busy (init_busy),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_kind    (q_kind),
		.q_key     (q_key),
		.q_home    (q_home),
		.q_mask    (q_mask)
	);

	lphjt_back #(
		.MAX_LOG2_SLOTS(MAX_LOG2_SLOTS),
		.KEY_BITS      (KEY_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_kind   (q_kind),
		.q_key    (q_key),
		.q_home   (q_home),
		.q_mask   (q_mask),
		.init_busy(init_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// tb: self-checking bench for linear_probe_hash_join_table, with an in-bench
// model of the slot table and hit count, and stream, stall and apb drivers
// depends on lphjt_pkg and linear_probe_hash_join_table
module tb;
	import lphjt_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SLOTS       = 1 << MAX_LOG2_SLOTS_DEF;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_WORDS = 100;
	localparam int POOL_DEPTH  = 48;

	typedef struct packed {
		logic                  matched;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  table_full;
		logic [COUNT_W-1:0]    match_count;
	} join_result_t;

	// mirror of the slot table; one expected word per accepted item
	class join_table_tracker;
		bit                  occupied [SLOTS];
		logic [KEY_IN_W-1:0] stored_key [SLOTS];
		logic [COUNT_W-1:0]  hit_total;
		logic [LOG2_W-1:0]   table_log2;
		join_result_t        pending_results [$];
		int                  fail_count;

		function new();
			foreach (occupied[i]) occupied[i] = 1'b0;
			hit_total  = '0;
			table_log2 = TABLE_LOG2_RESET;
			fail_count = 0;
		endfunction

		function void set_table_log2(logic [CFG_DATA_W-1:0] value);
			table_log2 = value[LOG2_W-1:0];
		endfunction

		function int unsigned slot_mask();
			int unsigned lg;
			lg = table_log2;
			if (lg < 1) lg = 1;
			if (lg > MAX_LOG2_SLOTS_DEF) lg = MAX_LOG2_SLOTS_DEF;
			return (1 << lg) - 1;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		task report(string msg);
			if (fail_count < 40) $display("%0t mismatch: %s", $time, msg);
			fail_count++;
		endtask

		function void accept_word(logic [KIND_W-1:0] kind, logic [KEY_IN_W-1:0] key);
			join_result_t r;
			int unsigned mask, home, idx;
			bit stopped, hit;
			mask    = slot_mask();
			home    = key & mask;
			idx     = home;
			stopped = 1'b0;
			hit     = 1'b0;
			r       = '0;
			case (kind)
				KIND_INSERT: begin
					for (int unsigned n = 0; n <= mask; n++) begin
						if (!occupied[idx]) begin
							stopped = 1'b1;
							break;
						end
						idx = (idx + 1) & mask;
					end
					if (stopped) begin
						occupied[idx]   = 1'b1;
						stored_key[idx] = key;
						r.slot          = idx[SLOT_OUT_W-1:0];
					end else begin
						r.table_full = 1'b1;
						r.slot       = home[SLOT_OUT_W-1:0];
					end
				end
				KIND_PROBE: begin
					for (int unsigned n = 0; n <= mask; n++) begin
						if (!occupied[idx]) begin
							stopped = 1'b1;
							break;
						end
						if (stored_key[idx] == key) begin
							stopped = 1'b1;
							hit     = 1'b1;
							break;
						end
						idx = (idx + 1) & mask;
					end
					r.matched = hit;
					r.slot    = stopped ? idx[SLOT_OUT_W-1:0] : home[SLOT_OUT_W-1:0];
					if (hit && hit_total != '1) hit_total++;
				end
				KIND_CLEAR: begin
					foreach (occupied[i]) occupied[i] = 1'b0;
					hit_total = '0;
				end
				default: ;
			endcase
			r.match_count = hit_total;
			pending_results.push_back(r);
		endfunction

		task check_word(logic [OUT_DATA_W-1:0] word);
			join_result_t e;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected word %h", word));
			end else begin
				e = pending_results.pop_front();
				if (word[0] !== e.matched)
					report($sformatf("matched %b, want %b", word[0], e.matched));
				if (word[SLOT_OUT_W:1] !== e.slot)
					report($sformatf("slot %0d, want %0d", word[SLOT_OUT_W:1], e.slot));
				if (word[SLOT_OUT_W+1] !== e.table_full)
					report($sformatf("table_full %b, want %b",
						word[SLOT_OUT_W+1], e.table_full));
				if (word[SLOT_OUT_W+2 +: COUNT_W] !== e.match_count)
					report($sformatf("match_count %0d, want %0d",
						word[SLOT_OUT_W+2 +: COUNT_W], e.match_count));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]     s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [PADDR_W-1:0]    paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	join_table_tracker   tracker = new();
	int                  send_idle;
	int                  recv_idle;
	bit                  hold_req;
	int                  quiet_cycles;
	logic [KEY_IN_W-1:0] key_pool [$];

	linear_probe_hash_join_table u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// output side: random stalls, plus one long hold when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) tracker.check_word(m_tdata);
	end

	// watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[linear_probe_hash_join_table] ERROR");
			$finish;
		end
	end

	task set_idling(input int s_pct, input int r_pct);
		send_idle = s_pct;
		recv_idle = r_pct;
	endtask

	task send_word(input logic [KIND_W-1:0] kind, input logic [KEY_IN_W-1:0] key);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= key;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		tracker.accept_word(kind, key);
	endtask

	task drain();
		s_tvalid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
	endtask

	task apb_write(input logic [CFG_DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_IDX_TABLE_LOG2, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_table_log2(value);
	endtask

	// mostly inserts and probes, probes mostly of keys seen lately, so they walk real clusters
	task run_phase(input int hold_at);
		int pick, r;
		logic [KEY_IN_W-1:0] key;
		for (int w = 0; w < PHASE_WORDS; w++) begin
			if (w == hold_at) hold_req = 1'b1;
			pick = $urandom_range(99);
			r    = $urandom_range(9);
			if (pick < 42) begin
				if (r < 2 && key_pool.size() > 0)
					key = key_pool[$urandom_range(key_pool.size() - 1)];
				else
					key = $urandom;
				send_word(KIND_INSERT, key);
				key_pool.push_back(key);
				if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
			end else if (pick < 95) begin
				if (r < 6 && key_pool.size() > 0)
					key = key_pool[$urandom_range(key_pool.size() - 1)];
				else if (r < 8 && key_pool.size() > 0)
					key = key_pool[$urandom_range(key_pool.size() - 1)] ^ 32'h8000_0000;
				else
					key = $urandom;
				send_word(KIND_PROBE, key);
			end else if (pick < 97) begin
				send_word(KIND_CLEAR, $urandom);
				key_pool.delete();
			end else begin
				send_word(KIND_UNUSED, $urandom);
			end
		end
	endtask

	initial begin
		int phase_log2 [12];
		phase_log2   = '{1, 2, 4, 3, 5, 0, 6, 8, 2, 10, 15, 7};
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		hold_req     = 1'b0;
		quiet_cycles = 0;
		set_idling(26, 86);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// size below range is taken as two slots
		apb_write(32'd0);
		send_word(KIND_INSERT, 32'h0000_0000);
		send_word(KIND_INSERT, 32'h0000_0002);
		send_word(KIND_INSERT, 32'hFFFF_FFFC);  // table full
		send_word(KIND_PROBE, 32'h0000_0002);
		send_word(KIND_PROBE, 32'h0000_0006);   // full sweep miss
		send_word(KIND_PROBE, 32'h0000_0000);
		send_word(KIND_UNUSED, 32'hFFFF_FFFF);
		send_word(KIND_CLEAR, 32'hFFFF_FFFF);
		send_word(KIND_PROBE, 32'h0000_0000);
		drain();

		// size above range is taken as the largest
		apb_write(32'hFFFF_FFFF);
		send_word(KIND_INSERT, 32'hFFFF_FFFF);
		send_word(KIND_INSERT, 32'hFFFF_FFFF);  // duplicate wraps to slot 0
		send_word(KIND_PROBE, 32'hFFFF_FFFF);
		send_word(KIND_INSERT, 32'h0000_0000);
		send_word(KIND_PROBE, 32'hAAAA_AAAA);
		send_word(KIND_PROBE, 32'h5555_5555);
		send_word(KIND_INSERT, 32'h5555_5555);
		send_word(KIND_PROBE, 32'h5555_5555);
		send_word(KIND_PROBE, 32'h8000_0000);
		drain();

		// shrink with entries left above the new size
		apb_write(32'd3);
		send_word(KIND_PROBE, 32'hFFFF_FFFF);
		send_word(KIND_PROBE, 32'h0000_0000);
		send_word(KIND_INSERT, 32'h7FFF_FFF8);
		drain();

		for (int p = 0; p < 12; p++) begin
			if (p < 4)
				set_idling(26, 86);
			else if (p < 8)
				set_idling(86, 26);
			else
				set_idling(0, 0);
			apb_write(phase_log2[p]);
			run_phase((p == 2 || p == 9) ? 30 : -1);
			drain();
		end

		repeat (1100) @(posedge clk);
		if (tracker.fail_count == 0 && tracker.pending() == 0)
			$display("[linear_probe_hash_join_table] OK");
		else
			$display("[linear_probe_hash_join_table] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
sv/lphjt_pkg.sv
sv/lphjt_front.sv
sv/lphjt_back.sv
sv/linear_probe_hash_join_table.sv
tb/tb.sv
